[rtl/ncc_pkg.sv]
// types and constants shared by the nearest centroid classifier modules
`timescale 1ns / 1ps
package ncc_pkg;

  localparam int COORD_W   = 16;
  localparam int SLOT_W    = 4;
  localparam int CIU_W     = 5;
  localparam int CLUSTER_W = 4;
  localparam int COUNT_W   = 32;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = SQ_W + 1;

  localparam logic [CIU_W-1:0] CIU_RESET = 5'd10;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic                      slot_ok;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_CNT_RD,
    ST_CNT_WR
  } back_state_t;

endpackage

[rtl/ncc_front.sv]
// input stage: accepts transactions and decodes them into commands
`timescale 1ns / 1ps
module ncc_front import ncc_pkg::*; #(
  parameter int MAX_CENTROIDS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      push_valid,
  input  logic                      push_ready,
  output cmd_t                      push_cmd
);

  logic fr_vld_r;
  logic fr_vld_nxt;
  cmd_t fr_cmd_r;
  logic accept;

  assign in_stall   = fr_vld_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = fr_vld_r;
  assign push_cmd   = fr_cmd_r;

  always_comb begin
    fr_vld_nxt = fr_vld_r;
    if (accept) begin
      fr_vld_nxt = 1'b1;
    end else if (push_ready) begin
      fr_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r.op      <= op_t'(in_func);
      fr_cmd_r.slot_ok <= (32'(in_slot) < MAX_CENTROIDS);
      fr_cmd_r.slot    <= in_slot;
      fr_cmd_r.x       <= in_coord_x;
      fr_cmd_r.y       <= in_coord_y;
    end
  end

endmodule

[rtl/ncc_cmd_queue.sv]
// two entry command queue between the front and the back
`timescale 1ns / 1ps
module ncc_cmd_queue import ncc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/ncc_back.sv]
// execution engine: centroid store, distance pipeline, cluster counts, result register
`timescale 1ns / 1ps
module ncc_back import ncc_pkg::*; #(
  parameter int MAX_CENTROIDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CIU_W-1:0]     cfg_ciu,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CLUSTER_W-1:0] out_cluster,
  output logic [COUNT_W-1:0]   out_cluster_total
);

  localparam int IDX_W = $clog2(MAX_CENTROIDS);

  back_state_t state_r;
  back_state_t state_nxt;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] j_nxt;
  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] last_nxt;
  logic [IDX_W-1:0] last_sel;

  // centroid store
  logic [COORD_W-1:0] tab_x [MAX_CENTROIDS];
  logic [COORD_W-1:0] tab_y [MAX_CENTROIDS];
  logic               tab_we;

  // point under classification
  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;
  logic                      lat_pt;

  // issue
  logic             iss_vld;
  logic [IDX_W-1:0] iss_idx;
  logic             iss_first;
  logic             iss_last;

  // pipeline stages
  logic               s1_vld_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [COORD_W-1:0] rd_x_r, rd_y_r;
  logic               s2_vld_r, s2_first_r, s2_last_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [COORD_W-1:0] adx_r, ady_r;
  logic               s3_vld_r, s3_first_r, s3_last_r;
  logic [IDX_W-1:0]   s3_idx_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;

  logic [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0] adx_c, ady_c;
  logic [DIST_W-1:0]  dist_c;
  logic [DIST_W-1:0]  best_d_r;
  logic [IDX_W-1:0]   best_idx_r;

  // cluster counts
  logic [COUNT_W-1:0]       cnt_mem [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] cnt_vld_r;
  logic [COUNT_W-1:0]       cnt_rd_r;
  logic                     cnt_hit_r;
  logic [COUNT_W-1:0]       cnt_cur;
  logic [COUNT_W-1:0]       cnt_new;
  logic                     cnt_we;

  // result register
  logic                 out_valid_r;
  logic [CLUSTER_W-1:0] out_cluster_r;
  logic [COUNT_W-1:0]   out_total_r;
  logic                 out_load;

  assign out_valid         = out_valid_r;
  assign out_cluster       = out_cluster_r;
  assign out_cluster_total = out_total_r;

  // last slot searched, zero means one, clamp to table depth
  always_comb begin
    if (cfg_ciu == '0) begin
      last_sel = '0;
    end else if (32'(cfg_ciu) > MAX_CENTROIDS) begin
      last_sel = IDX_W'(MAX_CENTROIDS - 1);
    end else begin
      last_sel = IDX_W'(cfg_ciu - CIU_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    tab_we    = 1'b0;
    lat_pt    = 1'b0;
    iss_vld   = 1'b0;
    iss_idx   = j_r;
    iss_first = 1'b0;
    iss_last  = 1'b0;
    cnt_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_LOAD) begin
            tab_we = q_cmd.slot_ok;
          end else begin
            lat_pt    = 1'b1;
            iss_vld   = 1'b1;
            iss_idx   = '0;
            iss_first = 1'b1;
            iss_last  = (last_sel == '0);
            last_nxt  = last_sel;
            j_nxt     = IDX_W'(1);
            state_nxt = iss_last ? ST_DRAIN : ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        iss_vld  = 1'b1;
        iss_last = (j_r == last_r);
        j_nxt    = j_r + IDX_W'(1);
        if (iss_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_vld_r && s3_last_r) begin
          state_nxt = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        if (!out_valid_r || !out_stall) begin
          cnt_we    = 1'b1;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // absolute differences and the sum of squares
  always_comb begin
    dx     = {px_r[COORD_W-1], px_r} - {rd_x_r[COORD_W-1], rd_x_r};
    dy     = {py_r[COORD_W-1], py_r} - {rd_y_r[COORD_W-1], rd_y_r};
    adx_c  = dx[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dx) : dx[COORD_W-1:0];
    ady_c  = dy[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dy) : dy[COORD_W-1:0];
    dist_c = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // saturating count
  always_comb begin
    cnt_cur = cnt_hit_r ? cnt_rd_r : '0;
    cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      last_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      last_r   <= last_nxt;
      s1_vld_r <= iss_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (cnt_we) begin
        cnt_vld_r[best_idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_x[IDX_W'(q_cmd.slot)] <= q_cmd.x;
      tab_y[IDX_W'(q_cmd.slot)] <= q_cmd.y;
    end
    rd_x_r <= tab_x[iss_idx];
    rd_y_r <= tab_y[iss_idx];
  end

  always_ff @(posedge clk) begin
    if (lat_pt) begin
      px_r <= q_cmd.x;
      py_r <= q_cmd.y;
    end
    s1_idx_r   <= iss_idx;
    s1_first_r <= iss_first;
    s1_last_r  <= iss_last;
    s2_idx_r   <= s1_idx_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    adx_r      <= adx_c;
    ady_r      <= ady_c;
    s3_idx_r   <= s2_idx_r;
    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    sqx_r      <= adx_r * adx_r;
    sqy_r      <= ady_r * ady_r;
    // strict less keeps the lowest index on ties
    if (s3_vld_r && (s3_first_r || dist_c < best_d_r)) begin
      best_d_r   <= dist_c;
      best_idx_r <= s3_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[best_idx_r] <= cnt_new;
    end
    cnt_rd_r  <= cnt_mem[best_idx_r];
    cnt_hit_r <= cnt_vld_r[best_idx_r];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cluster_r <= CLUSTER_W'(best_idx_r);
      out_total_r   <= cnt_new;
    end
  end

endmodule

[rtl/nearest_centroid_classifier_core.sv]
// top level of the nearest centroid classifier
//
// input channel: in_valid/in_stall with in_func, in_slot, in_coord_x, in_coord_y.
//   func 0 loads centroid (x,y) into a slot, func 1 classifies point (x,y).
// result channel: out_valid/out_stall with out_cluster, out_cluster_total,
//   one transaction per classify, none per load.
// config channel: cfg_valid/cfg_ready with cfg_centroids_in_use, always ready;
//   write only while the block is idle.
// engine occupancy: a load is done once the queue pops it; a classify holds the engine
//   through search, pipeline drain, count read and count write, as the centroid store
//   delivers one centroid per cycle into the distance pipeline.
// a classify passes the front register, the queue, the search and the count update
//   before out_valid rises; the count write waits while a held result is stalled.
// a two entry queue lets new transactions be accepted while the engine works
//   or while a result waits on out_stall; the held result does not change.
// reset clears the queue, the result register and all cluster counts, and sets
//   centroids_in_use to 10; centroids must be loaded before use.
`timescale 1ns / 1ps
module nearest_centroid_classifier_core import ncc_pkg::*; #(
  parameter int MAX_CENTROIDS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CLUSTER_W-1:0]      out_cluster,
  output logic [COUNT_W-1:0]        out_cluster_total,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CIU_W-1:0]          cfg_centroids_in_use
);

  logic [CIU_W-1:0] ciu_r;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r <= CIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ciu_r <= cfg_centroids_in_use;
    end
  end

  ncc_front #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_slot    (in_slot),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ncc_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  ncc_back #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_ciu           (ciu_r),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cluster       (out_cluster),
    .out_cluster_total (out_cluster_total)
  );

endmodule

[dv/tb.sv]
// self-checking testbench for the nearest centroid classifier core
`timescale 1ns / 1ps
module tb;
  import ncc_pkg::*;

  localparam int NUM_SLOTS     = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 85;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [COUNT_W-1:0]   total;
  } assignment_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_func = 1'b0;
  logic [SLOT_W-1:0]         in_slot = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CLUSTER_W-1:0]      out_cluster;
  logic [COUNT_W-1:0]        out_cluster_total;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CIU_W-1:0]          cfg_centroids_in_use = '0;

  logic signed [COORD_W-1:0] centroid_x [NUM_SLOTS];
  logic signed [COORD_W-1:0] centroid_y [NUM_SLOTS];
  logic [COUNT_W-1:0]        assign_count [NUM_SLOTS];
  logic [CIU_W-1:0]          centroid_limit = CIU_RESET;
  assignment_t               expected_assignments [$];

  bit src_idle_on = 1'b0;
  bit dst_idle_on = 1'b0;
  logic hold_req = 1'b0;
  logic hold_armed = 1'b1;
  int stall_left = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int points_sent = 0;
  int results_checked = 0;
  int tie_points = 0;
  int cfg_writes = 0;

  nearest_centroid_classifier_core #(.MAX_CENTROIDS(NUM_SLOTS)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_slot              (in_slot),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cluster          (out_cluster),
    .out_cluster_total    (out_cluster_total),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_centroids_in_use (cfg_centroids_in_use)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  function automatic logic [DIST_W-1:0] squared_distance(
    logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
    logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy
  );
    logic signed [COORD_W:0] dx, dy;
    logic [SQ_W-1:0]         sx, sy;
    dx = px - cx;
    dy = py - cy;
    sx = dx * dx;
    sy = dy * dy;
    return {1'b0, sx} + {1'b0, sy};
  endfunction

  task automatic predict_item(op_t op, logic [SLOT_W-1:0] slot,
                              logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    int                searched;
    int                best;
    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] cand_dist;
    bit                tied;
    assignment_t       result;
    if (op == OP_LOAD) begin
      centroid_x[slot] = x;
      centroid_y[slot] = y;
      loads_sent++;
    end else begin
      searched = (centroid_limit == 0) ? 1 :
                 (centroid_limit > NUM_SLOTS) ? NUM_SLOTS : int'(centroid_limit);
      best = 0;
      tied = 1'b0;
      best_dist = squared_distance(x, y, centroid_x[0], centroid_y[0]);
      for (int j = 1; j < searched; j++) begin
        cand_dist = squared_distance(x, y, centroid_x[j], centroid_y[j]);
        if (cand_dist < best_dist) begin
          best_dist = cand_dist;
          best = j;
          tied = 1'b0;
        end else if (cand_dist == best_dist) begin
          tied = 1'b1;
        end
      end
      if (assign_count[best] != '1) assign_count[best]++;
      result.cluster = CLUSTER_W'(best);
      result.total = assign_count[best];
      expected_assignments.push_back(result);
      points_sent++;
      if (tied) tie_points++;
    end
  endtask

  task automatic send_item(op_t op, logic [SLOT_W-1:0] slot,
                           logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_func <= op;
    in_slot <= slot;
    in_coord_x <= x;
    in_coord_y <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(op, slot, x, y);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_centroid_limit(logic [CIU_W-1:0] limit);
    cfg_centroids_in_use <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    centroid_limit = limit;
    cfg_writes++;
  endtask

  function automatic void pick_point(output logic signed [COORD_W-1:0] x,
                                     output logic signed [COORD_W-1:0] y);
    int anchor;
    anchor = $urandom_range(0, NUM_SLOTS - 1);
    case ($urandom_range(0, 9))
      0, 1: begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end
      2, 3: begin
        x = COORD_W'(int'($urandom_range(0, 6)) - 3);
        y = COORD_W'(int'($urandom_range(0, 6)) - 3);
      end
      4: begin
        x = centroid_x[anchor];
        y = centroid_y[anchor];
      end
      default: begin
        x = centroid_x[anchor] + COORD_W'(int'($urandom_range(0, 512)) - 256);
        y = centroid_y[anchor] + COORD_W'(int'($urandom_range(0, 512)) - 256);
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    assignment_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_assignments.size() == 0) begin
        note_error($sformatf("unexpected transaction cluster %0d total %0d",
                             out_cluster, out_cluster_total));
      end else begin
        want = expected_assignments.pop_front();
        results_checked++;
        if (out_cluster !== want.cluster) begin
          note_error($sformatf("cluster expected %0d actual %0d", want.cluster, out_cluster));
        end
        if (out_cluster_total !== want.total) begin
          note_error($sformatf("cluster_total expected %0d actual %0d",
                               want.total, out_cluster_total));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_req && hold_armed) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (dst_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
      if (!hold_req) hold_armed <= 1'b1;
    end
  end

  // every slot is loaded here so no later search reads an unwritten entry
  task automatic test_table_load();
    src_idle_on = 1'b1;
    dst_idle_on = 1'b1;
    send_item(OP_LOAD, 4'd0, 16'sh8000, 16'sh8000);
    send_item(OP_LOAD, 4'd1, 16'sd256, -16'sd512);
    send_item(OP_LOAD, 4'd2, 16'sd260, -16'sd512);
    send_item(OP_LOAD, 4'd3, 16'sd256, -16'sd512);
    for (int s = 4; s < NUM_SLOTS - 1; s++) begin
      send_item(OP_LOAD, SLOT_W'(s), COORD_W'($urandom), COORD_W'($urandom));
    end
    send_item(OP_LOAD, 4'd15, 16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_default_limit();
    send_item(OP_CLASSIFY, 4'd15, 16'sh8000, 16'sh8000);
    send_item(OP_CLASSIFY, 4'd0, 16'sh7fff, 16'sh7fff);
    send_item(OP_CLASSIFY, 4'd9, 16'sh7fff, 16'sh8000);
    send_item(OP_CLASSIFY, 4'd5, centroid_x[12], centroid_y[12]);
  endtask

  task automatic test_tie_breaking();
    send_item(OP_CLASSIFY, 4'd7, 16'sd258, -16'sd512);
    send_item(OP_CLASSIFY, 4'd3, 16'sd258, -16'sd512);
    send_item(OP_CLASSIFY, 4'd10, 16'sd256, -16'sd512);
  endtask

  task automatic test_limit_extremes();
    logic [CIU_W-1:0] limits [4] = '{5'd16, 5'd0, 5'd31, 5'd1};
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_centroid_limit(limits[k]);
      send_item(OP_CLASSIFY, 4'd12, 16'sh7fff, 16'sh7fff);
    end
  endtask

  task automatic test_output_backpressure();
    logic signed [COORD_W-1:0] x, y;
    wait_idle();
    write_centroid_limit(5'd16);
    src_idle_on = 1'b0;
    dst_idle_on = 1'b0;
    hold_req <= 1'b1;
    for (int k = 0; k < 12; k++) begin
      pick_point(x, y);
      send_item(OP_CLASSIFY, SLOT_W'($urandom), x, y);
    end
    hold_req <= 1'b0;
  endtask

  task automatic test_random_traffic();
    logic signed [COORD_W-1:0] x, y;
    logic [CIU_W-1:0]          limit;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      limit = (phase % 2) ? CIU_W'($urandom_range(0, 31)) : CIU_W'($urandom_range(8, 16));
      write_centroid_limit(limit);
      src_idle_on = (phase < RANDOM_PHASES - 1) && (phase != 1);
      dst_idle_on = (phase < RANDOM_PHASES - 1) && (phase != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_point(x, y);
        if ($urandom_range(0, 9) < 3) begin
          send_item(OP_LOAD, SLOT_W'($urandom), x, y);
        end else begin
          send_item(OP_CLASSIFY, SLOT_W'($urandom), x, y);
        end
      end
    end
  endtask

  initial begin
    foreach (assign_count[i]) assign_count[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_default_limit();
    test_tie_breaking();
    test_limit_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    $display("covered %0d transactions: %0d centroid loads, %0d points, %0d results checked",
             items_sent, loads_sent, points_sent, results_checked);
    $display("%0d centroid count writes, %0d points tied for nearest, %0d mismatches",
             cfg_writes, tie_points, error_count);
    if (error_count == 0 && expected_assignments.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
